@@ src/sm3_pkg.sv @@
// sm3 shared types and constants
// block layout, queue item, initial value and round constants; no dependencies
package sm3_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;
    typedef logic [60:0] byte_count_t;

    typedef struct packed {
        logic   is_last;
        block_t words;
    } blk_item_t;

    typedef struct packed {
        logic      valid;
        blk_item_t item;
    } blk_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam word_t IV_WORDS [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam word_t T_LOW        = 32'h79CC4519;
    localparam word_t T_HIGH       = 32'h7A879D8A;
    localparam word_t T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

@@ src/sm3_front.sv @@
// sm3 front end: takes bytes, packs big-endian blocks, appends padding and length
// depends on sm3_pkg; pushes finished blocks into the block queue
module sm3_front
    import sm3_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    input  logic          s_tlast,
    input  queue_status_t q_status,
    output blk_push_t     push
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PAD,
        ST_PAD2
    } front_state_t;

    front_state_t state_reg;
    byte_count_t  cnt_reg;
    block_t       blk_reg;

    logic         accept;
    logic [5:0]   pos;
    logic [1:0]   lane;
    logic [63:0]  bit_len;
    block_t       blk_ins;
    block_t       padded;
    block_t       padded_len;
    block_t       zero_len;

    always_comb begin
        accept  = s_tvalid && s_tready;
        pos     = cnt_reg[5:0];
        lane    = ~pos[1:0];
        bit_len = {cnt_reg, 3'b000};

        blk_ins = blk_reg;
        if (s_tuser) begin
            blk_ins[pos[5:2]][{lane, 3'b000} +: 8] = s_tdata;
        end

        padded = blk_reg;
        for (int k = 0; k < 64; k++) begin
            if (6'(k) == pos) begin
                padded[k / 4][(3 - (k % 4)) * 8 +: 8] = PAD_BYTE;
            end else if (6'(k) > pos) begin
                padded[k / 4][(3 - (k % 4)) * 8 +: 8] = 8'h00;
            end
        end

        padded_len     = padded;
        padded_len[14] = bit_len[63:32];
        padded_len[15] = bit_len[31:0];

        zero_len     = '0;
        zero_len[14] = bit_len[63:32];
        zero_len[15] = bit_len[31:0];
    end

    assign s_tready = (state_reg == ST_FILL) && !q_status.full;

    always_comb begin
        push = '0;
        unique case (state_reg)
            ST_FILL: begin
                push.valid      = accept && s_tuser && (pos == LAST_POS);
                push.item.words = blk_ins;
            end
            ST_PAD: begin
                push.valid = !q_status.full;
                if (pos < LEN_POS) begin
                    push.item.is_last = 1'b1;
                    push.item.words   = padded_len;
                end else begin
                    push.item.words = padded;
                end
            end
            ST_PAD2: begin
                push.valid        = !q_status.full;
                push.item.is_last = 1'b1;
                push.item.words   = zero_len;
            end
            default: begin
                push = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_FILL: begin
                    if (accept) begin
                        if (s_tuser) begin
                            cnt_reg <= cnt_reg + 61'd1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (!q_status.full) begin
                        if (pos < LEN_POS) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_FILL;
                        end else begin
                            state_reg <= ST_PAD2;
                        end
                    end
                end
                ST_PAD2: begin
                    if (!q_status.full) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FILL;
                    end
                end
                default: begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL && accept) begin
            blk_reg <= blk_ins;
        end
    end

endmodule

@@ src/sm3_queue.sv @@
// sm3 block queue between front end and compression core
// depends on sm3_pkg; register-based fifo of whole blocks
module sm3_queue
    import sm3_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  blk_push_t     push,
    input  logic          pop,
    output blk_item_t     head,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

@@ src/sm3_core.sv @@
// sm3 compression core: message expansion window and one round per cycle
// depends on sm3_pkg; holds the chaining value and the digest output register
module sm3_core
    import sm3_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  blk_item_t     head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [255:0]  m_tdata
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } core_state_t;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t perm0(input word_t x);
        perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic word_t perm1(input word_t x);
        perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    core_state_t  state_reg;
    logic [5:0]   round_reg;
    logic         last_reg;
    word_t        tj_reg;
    word_t        cv_reg [8];
    word_t        r_reg  [8];
    word_t        w_reg  [16];
    logic         out_valid_reg;
    logic [255:0] out_data_reg;

    logic  early;
    word_t a12, ss1, ss2, ff, gg, tt1, tt2, new_w;
    word_t r_next  [8];
    word_t cv_next [8];

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty
                      && (!head.is_last || !out_valid_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        early = (round_reg[5:4] == 2'b00);
        a12   = rotl(r_reg[0], 12);
        ss1   = rotl(a12 + r_reg[4] + tj_reg, 7);
        ss2   = ss1 ^ a12;
        if (early) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];

        r_next[0] = tt1;
        r_next[1] = r_reg[0];
        r_next[2] = rotl(r_reg[1], 9);
        r_next[3] = r_reg[2];
        r_next[4] = perm0(tt2);
        r_next[5] = r_reg[4];
        r_next[6] = rotl(r_reg[5], 19);
        r_next[7] = r_reg[6];

        new_w = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 15))
                ^ rotl(w_reg[3], 7) ^ w_reg[10];

        for (int i = 0; i < 8; i++) begin
            cv_next[i] = cv_reg[i] ^ r_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            cv_reg        <= IV_WORDS;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        round_reg <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LAST_POS) begin
                        state_reg <= ST_IDLE;
                        if (last_reg) begin
                            out_valid_reg <= 1'b1;
                            cv_reg        <= IV_WORDS;
                        end else begin
                            cv_reg <= cv_next;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && pop) begin
            last_reg <= head.is_last;
            tj_reg   <= T_LOW;
            r_reg    <= cv_reg;
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= head.words[i];
            end
        end else if (state_reg == ST_RUN) begin
            tj_reg <= (round_reg == 6'd15) ? T_HIGH_ROT16 : rotl(tj_reg, 1);
            r_reg  <= r_next;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= new_w;
            if (round_reg == LAST_POS && last_reg) begin
                for (int i = 0; i < 4; i++) begin
                    out_data_reg[64 * i +: 64] <= {cv_next[2 * i], cv_next[2 * i + 1]};
                end
            end
        end
    end

endmodule

@@ src/sm3_hash_engine.sv @@
// sm3 hash engine top level: front end, block queue and compression core
// depends on sm3_pkg, sm3_front, sm3_queue and sm3_core
//
//  channel | dir | tdata                                  | tuser      | tlast
//  s_      | in  | [7:0] data_byte                        | byte_valid | last
//  m_      | out | [63:0] word0 .. [255:192] digest_word3 | -          | -
//
// bytes enter at one per cycle while the queue has room and the front end is in ST_FILL;
// a last item adds the ST_PAD state, and ST_PAD2 when the length does not fit
// the core loads a block and then runs 64 rounds on it, one round per cycle
// the digest is registered after the rounds on the final block; when the length does not
// fit, padding makes that final block a second one after the last data block
// synchronous active-low reset; the chaining value returns to the initial value
// a stalled result holds in the output register; a final block waits until it is free
module sm3_hash_engine
    import sm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // byte_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // digest_word0, digest_word1, digest_word2, digest_word3
);

    blk_push_t     push;
    blk_item_t     head;
    queue_status_t q_status;
    logic          pop;

    sm3_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push)
    );

    sm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    sm3_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !q_status.full)
        else $error("block pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("block popped from an empty queue");

    a_final_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.is_last) |-> !m_tvalid)
        else $error("final block started while a digest is still pending");

    a_status_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

endmodule
